// ----- hw/rtl/lifo_stack_with_sum_and_max_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the stack block
// Concurrent checks are written through these so they can be compiled out.
// ---------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_SUM_AND_MAX_TOP_DEFINES_SVH
`define LIFO_STACK_WITH_SUM_AND_MAX_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// check outside reset
`define LSSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds across reset
`define LSSM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSSM_ASSERT(lbl, prop, msg)
`define LSSM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/lssm_pkg.sv -----
// ---------------------------------------------------------------------------
// lssm_pkg
// Shared types and constants for the stack with running sum and maximum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lssm_pkg;

  localparam int DEPTH = 256;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_POP_EMPTY  = 2'd1,
    STAT_PUSH_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    req_t               req_type;
    logic signed [31:0] push_value;
  } in_beat_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] popped_value;
    logic signed [31:0] top_value;
    logic [8:0]         entry_count;
    logic signed [31:0] entry_sum;
    logic signed [31:0] largest_value;
  } out_beat_t;

  // one stack position: the entry and the largest value from the bottom up to it
  typedef struct packed {
    logic signed [31:0] entry;
    logic signed [31:0] maxv;
  } cell_t;

  // shift commands broadcast along the row
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

// ----- hw/rtl/lssm_cell.sv -----
// ---------------------------------------------------------------------------
// lssm_cell
// One stack position; takes its upper neighbour on push, lower one on pop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lssm_cell (
  input  logic                clk,
  input  lssm_pkg::shift_ctl_t ctl,
  input  lssm_pkg::cell_t     above,
  input  lssm_pkg::cell_t     below,
  output lssm_pkg::cell_t     q
);

  lssm_pkg::cell_t cell_r;
  lssm_pkg::cell_t cell_nxt;

  // move towards the bottom on push, towards the top on pop, else hold
  always_comb begin
    cell_nxt = cell_r;
    if (ctl.push) begin
      cell_nxt = above;
    end else if (ctl.pop) begin
      cell_nxt = below;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign q = cell_r;

endmodule

// ----- hw/rtl/lssm_chain.sv -----
// ---------------------------------------------------------------------------
// lssm_chain
// Row of stack cells; position 0 is always the top of the stack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lssm_chain (
  input  logic                 clk,
  input  lssm_pkg::shift_ctl_t ctl,
  input  lssm_pkg::cell_t      push_cell,
  output lssm_pkg::cell_t      top_cell,
  output lssm_pkg::cell_t      next_cell
);

  lssm_pkg::cell_t cells [lssm_pkg::DEPTH];

  // link each cell to its neighbours; the ends feed the new entry and themselves
  for (genvar i = 0; i < lssm_pkg::DEPTH; i++) begin : g_cell
    lssm_pkg::cell_t above_w;
    lssm_pkg::cell_t below_w;

    if (i == 0) begin : g_first
      assign above_w = push_cell;
    end else begin : g_mid_a
      assign above_w = cells[i-1];
    end

    if (i == lssm_pkg::DEPTH - 1) begin : g_last
      assign below_w = cells[i];
    end else begin : g_mid_b
      assign below_w = cells[i+1];
    end

    lssm_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above_w),
      .below (below_w),
      .q     (cells[i])
    );
  end

  assign top_cell  = cells[0];
  assign next_cell = cells[1];

endmodule

// ----- hw/rtl/lifo_stack_with_sum_and_max_top.sv -----
// A result is registered in the output register, or in the skid slot while the output is stalled.
// One push or pop per cycle while in_stall is low; the cell row shifts by one place on each accepted push or pop.
// A skid stage lets one more beat in while a result waits on a stalled output.
// Reset clears the fill count, running sum and output valids; cell contents
// are not cleared and are never read above the fill count.
// ---------------------------------------------------------------------------
// lifo_stack_with_sum_and_max_top
// Bounded stack with running sum and maximum, built as a shifting cell row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lifo_stack_with_sum_and_max_top_defines.svh"

module lifo_stack_with_sum_and_max_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lssm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lssm_pkg::out_beat_t out_data
);

  localparam int CW = lssm_pkg::CNT_W;

  logic [CW-1:0]       count_r, count_nxt;
  logic signed [31:0]  sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  lssm_pkg::out_beat_t out_r, out_nxt;
  lssm_pkg::out_beat_t skid_r, skid_nxt;

  lssm_pkg::shift_ctl_t ctl;
  lssm_pkg::cell_t      push_cell;
  lssm_pkg::cell_t      top_cell;
  lssm_pkg::cell_t      next_cell;
  lssm_pkg::out_beat_t  res;

  logic        in_accept;
  logic        out_take;
  logic        is_empty;
  logic        is_full;
  logic [31:0] count_ext;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CW'(lssm_pkg::DEPTH));

  // build the new top cell and shift commands, work out the result beat
  always_comb begin
    ctl       = '0;
    push_cell.entry = in_data.push_value;
    push_cell.maxv  = in_data.push_value;
    if (!is_empty && (top_cell.maxv > in_data.push_value)) begin
      push_cell.maxv = top_cell.maxv;
    end

    count_nxt = count_r;
    sum_nxt   = sum_r;

    res.status        = lssm_pkg::STAT_OK;
    res.popped_value  = '0;
    res.top_value     = is_empty ? 32'sd0 : top_cell.entry;
    res.largest_value = is_empty ? 32'sd0 : top_cell.maxv;

    if (in_data.req_type == lssm_pkg::REQ_PUSH) begin
      if (is_full) begin
        res.status = lssm_pkg::STAT_PUSH_FULL;
      end else begin
        ctl.push          = in_accept;
        count_nxt         = count_r + CW'(1);
        sum_nxt           = sum_r + in_data.push_value;
        res.top_value     = push_cell.entry;
        res.largest_value = push_cell.maxv;
      end
    end else begin
      if (is_empty) begin
        res.status = lssm_pkg::STAT_POP_EMPTY;
      end else begin
        ctl.pop           = in_accept;
        count_nxt         = count_r - CW'(1);
        sum_nxt           = sum_r - top_cell.entry;
        res.popped_value  = top_cell.entry;
        res.top_value     = (count_r == CW'(1)) ? 32'sd0 : next_cell.entry;
        res.largest_value = (count_r == CW'(1)) ? 32'sd0 : next_cell.maxv;
      end
    end

    count_ext       = 32'(count_nxt);
    res.entry_count = count_ext[8:0];
    res.entry_sum   = sum_nxt;

    if (!in_accept) begin
      count_nxt = count_r;
      sum_nxt   = sum_r;
    end
  end

  // output register with one skid slot behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_r || out_take) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  lssm_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .push_cell (push_cell),
    .top_cell  (top_cell),
    .next_cell (next_cell)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `LSSM_ASSERT(a_count_bound, count_r <= CW'(lssm_pkg::DEPTH), "fill count above depth")
  `LSSM_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid full with output empty")
  `LSSM_ASSERT(a_push_count, (in_accept && ctl.push) |=> (count_r == $past(count_r) + CW'(1)), "push did not advance count")
  `LSSM_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_valid_r && !skid_valid_r), "output valid after reset")

endmodule
